### hw/rtl/hsc_pkg.sv
// Shared types and constants for the RGB hue and skin classifier pipeline.
package hsc_pkg;

  // Channel and field widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 9;
  localparam int unsigned RemW    = 14;  // 60 * |diff| fits in 14 bits
  localparam int unsigned DshW    = 13;  // divisor shifted up by QuoW-1
  localparam int unsigned QuoW    = 6;   // quotient never exceeds 60
  localparam int unsigned ProdW   = 15;  // 100 * 255 fits in 15 bits
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SKIN_MIN_SAT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SKIN_MIN_VAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TINT_MIN_SAT = 2'd2;

  // Reset values of the thresholds
  localparam logic [ChanW-1:0] SKIN_MIN_SAT_RST = 8'd13;
  localparam logic [ChanW-1:0] SKIN_MIN_VAL_RST = 8'd40;
  localparam logic [ChanW-1:0] TINT_MIN_SAT_RST = 8'd33;

  // Hue sector base angles
  localparam logic [HueW-1:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [HueW-1:0] HUE_BASE_BLUE  = 9'd240;
  localparam logic [HueW-1:0] HUE_FULL_TURN  = 9'd360;

  // Ratio test constants, all scaled by 100
  localparam logic [ProdW-1:0] K_SCALE = 15'd100;
  localparam logic [ProdW-1:0] K_37    = 15'd37;
  localparam logic [ProdW-1:0] K_80    = 15'd80;
  localparam logic [ProdW-1:0] K_63    = 15'd63;
  localparam logic [ProdW-1:0] K_42    = 15'd42;
  localparam logic [ProdW-1:0] K_70    = 15'd70;

  // Which channel holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

  // Threshold set seen by the output stage
  typedef struct packed {
    logic [ChanW-1:0] skin_min_sat;
    logic [ChanW-1:0] skin_min_val;
    logic [ChanW-1:0] tint_min_sat;
  } cfg_t;

  // Per-pixel payload carried down the pipeline
  typedef struct packed {
    logic [RemW-1:0]  rem;     // partial remainder, starts as 60*|diff|
    logic [DshW-1:0]  dsh;     // divisor aligned to the next quotient bit
    logic [QuoW-1:0]  quo;     // quotient bits collected so far
    logic             neg;     // channel difference was negative
    max_sel_e         sel;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] sat;
    logic             red_max;
    logic             blue_max;
    logic             g_ge_b;
    logic             g_nz;
    logic             c37;     // 100g >= 37r
    logic             c80;     // 100g <= 80r
    logic             c63;     // 100b >= 63g
    logic             c42;     // 100b >= 42r
    logic             c70;     // 100g >= 70b
  } pix_t;

endpackage

### hw/rtl/hsc_front.sv
// First pipeline stage: max/min, saturation, hue difference and ratio compares.
module hsc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [hsc_pkg::ChanW-1:0]  red_i,
  input  logic [hsc_pkg::ChanW-1:0]  green_i,
  input  logic [hsc_pkg::ChanW-1:0]  blue_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output hsc_pkg::pix_t              pix_o
);
  import hsc_pkg::*;

  logic             valid_q;
  pix_t             pix_q, pix_d;
  logic             r_ge_g, r_ge_b, g_ge_b;
  logic [ChanW-1:0] mx, mn;
  logic [ChanW:0]   diff;      // signed difference, one extra bit
  logic [ChanW-1:0] diff_abs;
  logic [ProdW-1:0] r_w, g_w, b_w;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  // Channel ordering
  always_comb begin
    r_ge_g = red_i >= green_i;
    r_ge_b = red_i >= blue_i;
    g_ge_b = green_i >= blue_i;
    r_w    = ProdW'(red_i);
    g_w    = ProdW'(green_i);
    b_w    = ProdW'(blue_i);

    if (r_ge_g && r_ge_b) begin
      mx           = red_i;
      pix_d.sel    = SEL_RED;
      diff         = {1'b0, green_i} - {1'b0, blue_i};
    end else if (g_ge_b) begin
      mx           = green_i;
      pix_d.sel    = SEL_GREEN;
      diff         = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      mx           = blue_i;
      pix_d.sel    = SEL_BLUE;
      diff         = {1'b0, red_i} - {1'b0, green_i};
    end

    if (!r_ge_g && !g_ge_b)      mn = red_i > blue_i ? blue_i : red_i;
    else                         mn = red_i;
    // full min written out for clarity
    if (green_i <= red_i && green_i <= blue_i)     mn = green_i;
    else if (blue_i <= red_i && blue_i <= green_i) mn = blue_i;
    else                                           mn = red_i;

    diff_abs = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];

    // 60 * |diff| as 64x - 4x; divisor aligned to the top quotient bit
    pix_d.rem      = {diff_abs, 6'b0} - {4'b0, diff_abs, 2'b0};
    pix_d.dsh      = {mx - mn, 5'b0};
    pix_d.quo      = '0;
    pix_d.neg      = diff[ChanW];
    pix_d.value    = mx;
    pix_d.sat      = mx - mn;
    pix_d.red_max  = r_ge_g && r_ge_b;
    pix_d.blue_max = blue_i == mx;
    pix_d.g_ge_b   = g_ge_b;
    pix_d.g_nz     = green_i != '0;

    // Skin ratio tests by exact cross-multiplication
    pix_d.c37 = g_w * K_SCALE >= r_w * K_37;
    pix_d.c80 = g_w * K_SCALE <= r_w * K_80;
    pix_d.c63 = b_w * K_SCALE >= g_w * K_63;
    pix_d.c42 = b_w * K_SCALE >= r_w * K_42;
    pix_d.c70 = g_w * K_SCALE >= b_w * K_70;
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

endmodule

### hw/rtl/hsc_div_stage.sv
// Divider stage: two restoring-division steps of 60*|diff| by the saturation.
module hsc_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsc_pkg::pix_t pix_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsc_pkg::pix_t pix_o
);
  import hsc_pkg::*;

  logic valid_q;
  pix_t pix_q, pix_d, pix_m;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  // Two quotient bits per stage; the aligned divisor moves down one bit per step
  always_comb begin
    pix_m = pix_i;
    if (pix_i.rem >= {1'b0, pix_i.dsh}) begin
      pix_m.rem = pix_i.rem - {1'b0, pix_i.dsh};
      pix_m.quo = {pix_i.quo[QuoW-2:0], 1'b1};
    end else begin
      pix_m.quo = {pix_i.quo[QuoW-2:0], 1'b0};
    end
    pix_m.dsh = pix_i.dsh >> 1;

    pix_d = pix_m;
    if (pix_m.rem >= {1'b0, pix_m.dsh}) begin
      pix_d.rem = pix_m.rem - {1'b0, pix_m.dsh};
      pix_d.quo = {pix_m.quo[QuoW-2:0], 1'b1};
    end else begin
      pix_d.quo = {pix_m.quo[QuoW-2:0], 1'b0};
    end
    pix_d.dsh = pix_m.dsh >> 1;
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

endmodule

### hw/rtl/hsc_back.sv
// Output stage: hue assembly, skin and tint flags, result register.
module hsc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  hsc_pkg::pix_t                pix_i,
  input  hsc_pkg::cfg_t                cfg_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [hsc_pkg::HueW-1:0]     hue_o,
  output logic                         hue_valid_o,
  output logic [hsc_pkg::ChanW-1:0]    sat_o,
  output logic [hsc_pkg::ChanW-1:0]    value_o,
  output logic                         skin_o,
  output logic                         tint_o
);
  import hsc_pkg::*;

  logic             valid_q;
  logic [HueW-1:0]  hue_q, hue_d;
  logic             hue_valid_q, hue_valid_d;
  logic [ChanW-1:0] sat_q, value_q;
  logic             skin_q, skin_d;
  logic             tint_q, tint_d;
  logic [HueW-1:0]  base;
  logic [HueW-1:0]  ceil_mag;
  logic             ratio_ok;

  assign ready_o     = !valid_q || ready_i;
  assign valid_o     = valid_q;
  assign hue_o       = hue_q;
  assign hue_valid_o = hue_valid_q;
  assign sat_o       = sat_q;
  assign value_o     = value_q;
  assign skin_o      = skin_q;
  assign tint_o      = tint_q;

  // Hue: base +/- floor of the sector fraction
  always_comb begin
    case (pix_i.sel)
      SEL_GREEN: base = HUE_BASE_GREEN;
      SEL_BLUE:  base = HUE_BASE_BLUE;
      default:   base = pix_i.neg ? HUE_FULL_TURN : '0;
    endcase
    // a negative fraction floors away from zero: round the magnitude up
    ceil_mag    = HueW'(pix_i.quo) + HueW'(pix_i.rem != '0);
    hue_valid_d = pix_i.sat != '0;
    if (!hue_valid_d)    hue_d = '0;
    else if (pix_i.neg)  hue_d = base - ceil_mag;
    else                 hue_d = base + HueW'(pix_i.quo);
  end

  // Skin and tint flags
  always_comb begin
    if (pix_i.g_ge_b) ratio_ok = (pix_i.c37 && pix_i.c80) || (pix_i.g_nz && pix_i.c63);
    else              ratio_ok = pix_i.c42 && pix_i.c70;
    skin_d = (pix_i.sat > cfg_i.skin_min_sat) && (pix_i.value >= cfg_i.skin_min_val)
             && !pix_i.blue_max && pix_i.red_max && ratio_ok;
    tint_d = pix_i.sat > cfg_i.tint_min_sat;
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_q       <= hue_d;
      hue_valid_q <= hue_valid_d;
      sat_q       <= pix_i.sat;
      value_q     <= pix_i.value;
      skin_q      <= skin_d;
      tint_q      <= tint_d;
    end
  end

endmodule

### hw/rtl/rgb_pixel_hue_skin_classifier_core.sv
// Top level of the RGB pixel hue, saturation, value and skin classifier.
//
// Pixels enter on the s_axis stream (red, green, blue in tdata) and results
// leave on the m_axis stream, one result per pixel, in order.
// Three 8-bit thresholds are written through the cfg channel (index 0: skin
// minimum saturation, 1: skin minimum value, 2: tint minimum saturation;
// index 3 is ignored). cfg_ready_o is always high; write only while idle.
// A result is registered through one front stage, three divider stages with
// two quotient bits each, and one output stage.
// Throughput: one pixel per cycle while m_axis_tready stays high; the six-step hue
// division is spread over the three divider stages, so no stage holds more than two steps.
// When m_axis_tready is low, ready ripples back stage by stage: empty stages
// still fill, so up to five pixels are held before s_axis_tready drops.
// Nothing is lost or repeated during a stall.
// Reset (rst_ni low) empties the pipeline and loads the thresholds with
// 13, 40 and 33.
module rgb_pixel_hue_skin_classifier_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: red[7:0], green[15:8], blue[23:16]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hsc_pkg::InDataW-1:0]       s_axis_tdata,
  // tdata: hue_degrees[8:0], saturation_level[16:9], value_level[24:17], zero[31:25]
  // tuser: hue_valid[0], skin_flag[1], tintable_flag[2]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hsc_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [hsc_pkg::OutUserW-1:0]      m_axis_tuser,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hsc_pkg::ChanW-1:0]         cfg_data_i
);
  import hsc_pkg::*;

  cfg_t             cfg_q;
  logic             v1, r1, v2, r2, v3, r3, v4, r4;
  pix_t             p1, p2, p3, p4;
  logic [HueW-1:0]  hue;
  logic             hue_valid, skin, tint;
  logic [ChanW-1:0] sat, value;

  // Threshold registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skin_min_sat <= SKIN_MIN_SAT_RST;
      cfg_q.skin_min_val <= SKIN_MIN_VAL_RST;
      cfg_q.tint_min_sat <= TINT_MIN_SAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SKIN_MIN_SAT: cfg_q.skin_min_sat <= cfg_data_i;
        REG_SKIN_MIN_VAL: cfg_q.skin_min_val <= cfg_data_i;
        REG_TINT_MIN_SAT: cfg_q.tint_min_sat <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline
  hsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (v1),
    .ready_i (r1),
    .pix_o   (p1)
  );

  hsc_div_stage u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .pix_i   (p1),
    .valid_o (v2),
    .ready_i (r2),
    .pix_o   (p2)
  );

  hsc_div_stage u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .pix_i   (p2),
    .valid_o (v3),
    .ready_i (r3),
    .pix_o   (p3)
  );

  hsc_div_stage u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (r3),
    .pix_i   (p3),
    .valid_o (v4),
    .ready_i (r4),
    .pix_o   (p4)
  );

  hsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v4),
    .ready_o     (r4),
    .pix_i       (p4),
    .cfg_i       (cfg_q),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .hue_o       (hue),
    .hue_valid_o (hue_valid),
    .sat_o       (sat),
    .value_o     (value),
    .skin_o      (skin),
    .tint_o      (tint)
  );

  // Output packing
  assign m_axis_tdata = {7'b0, value, sat, hue};
  assign m_axis_tuser = {tint, skin, hue_valid};

`ifndef NO_ASSERTIONS
  // Grey pixels carry a zero hue
  a_grey_hue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[8:0] == '0)
    else $error("grey pixel with nonzero hue");

  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:0] < HUE_FULL_TURN)
    else $error("hue out of range");

  // Saturation never exceeds value
  a_sat_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:9] <= m_axis_tdata[24:17])
    else $error("saturation above value");

  // A skin pixel has a defined hue
  a_skin_has_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("skin flag on grey pixel");

  // Input backpressure only comes from a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the RGB pixel hue, saturation, value and skin classifier.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RandPerPhase = 120;
  localparam int unsigned MaxReported = 10;

  // One classified pixel, as it leaves the block
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic             hue_valid;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] value;
    logic             skin;
    logic             tint;
  } pixel_class_t;

  // Directed stimulus row; typed rows carry their own expected result
  typedef struct {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    bit               typed;
    pixel_class_t     res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // hue[8:0], sat[16:9], value[24:17], zero[31:25]
  logic [OutUserW-1:0]  m_axis_tuser;   // hue_valid[0], skin[1], tintable[2]
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [ChanW-1:0]     cfg_data_i;

  // Thresholds as the predictor sees them
  int unsigned thr_skin_sat;
  int unsigned thr_skin_val;
  int unsigned thr_tint_sat;

  pixel_class_t pending_classes [$];
  int unsigned  mismatch_cnt;
  int unsigned  burst_left;
  int unsigned  cycle_cnt;
  int unsigned  rdy_mode;
  int unsigned  rdy_mode_left;
  stim_row_t    dir_rows [23];

  rgb_pixel_hue_skin_classifier_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 100 MHz clock, low first so the first rising edge is at 5 ns
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predict hue, saturation, value and both flags for one pixel
  function automatic pixel_class_t classify_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                                  logic [ChanW-1:0] b);
    pixel_class_t res;
    int ri, gi, bi, mx, mn, d, num, h;
    bit skin;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d = mx - mn;
    res = '0;
    res.value = mx[ChanW-1:0];
    res.sat = d[ChanW-1:0];
    if (d != 0) begin
      // red wins ties, then green
      if (mx == ri) num = 60 * (gi - bi);
      else if (mx == gi) num = 120 * d + 60 * (bi - ri);
      else num = 240 * d + 60 * (ri - gi);
      // floor division, then wrap negative angles
      h = (num >= 0) ? num / d : -((-num + d - 1) / d);
      if (h < 0) h += 360;
      res.hue = h[HueW-1:0];
      res.hue_valid = 1'b1;
    end
    res.tint = (d > thr_tint_sat);
    // skin: only red-dominant pixels with enough saturation and brightness
    skin = 1'b0;
    if (d > thr_skin_sat && mx >= thr_skin_val && bi != mx && ri == mx) begin
      if (gi >= bi) begin
        skin = (100 * gi >= 37 * ri && 100 * gi <= 80 * ri) ||
               (gi != 0 && 100 * bi >= 63 * gi);
      end else begin
        skin = (100 * bi >= 42 * ri) && (100 * gi >= 70 * bi);
      end
    end
    res.skin = skin;
    return res;
  endfunction

  // One configuration transfer; the predictor follows it
  task automatic write_threshold(logic [CfgIdxW-1:0] idx, logic [ChanW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SKIN_MIN_SAT: thr_skin_sat = 32'(val);
      REG_SKIN_MIN_VAL: thr_skin_val = 32'(val);
      REG_TINT_MIN_SAT: thr_tint_sat = 32'(val);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Push one pixel; the sender idles between bursts of random length
  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                            bit typed, pixel_class_t typed_res);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_classes.push_back(typed ? typed_res : classify_pixel(r, g, b));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // mostly short bursts, sometimes long unbroken stretches
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Random pixel, biased toward the skin decision regions
  task automatic send_random_pixel();
    logic [ChanW-1:0] r, g, b, v;
    pixel_class_t none;
    int unsigned kind;
    none = '0;
    kind = $urandom_range(0, 9);
    r = ChanW'($urandom);
    g = ChanW'($urandom);
    b = ChanW'($urandom);
    case (kind)
      3, 4, 5: begin
        // red on top, green at least blue
        r = ChanW'($urandom_range(30, 255));
        g = ChanW'($urandom_range(r * 30 / 100, r * 85 / 100));
        b = ChanW'($urandom_range(0, g));
      end
      6: begin
        // red on top, blue at least green
        r = ChanW'($urandom_range(30, 255));
        b = ChanW'($urandom_range(r * 36 / 100, r));
        g = ChanW'($urandom_range(b * 60 / 100, b));
      end
      7: begin
        // two channels tied
        v = ChanW'($urandom);
        case ($urandom_range(0, 2))
          0: begin r = v; b = v; end
          1: begin r = v; g = v; end
          default: begin g = v; b = v; end
        endcase
      end
      8: begin
        // grey
        g = r;
        b = r;
      end
      9: begin
        // channels near the rails
        r = ($urandom_range(0, 1) != 0) ? ChanW'(255 - $urandom_range(0, 1))
                                        : ChanW'($urandom_range(0, 1));
        g = ($urandom_range(0, 1) != 0) ? ChanW'(255 - $urandom_range(0, 1))
                                        : ChanW'($urandom_range(0, 1));
        b = ($urandom_range(0, 1) != 0) ? ChanW'(255 - $urandom_range(0, 1))
                                        : ChanW'($urandom_range(0, 1));
      end
      default: ;
    endcase
    send_pixel(r, g, b, 1'b0, none);
  endtask

  // Let every expected result drain before touching the thresholds
  task automatic wait_drained();
    while (pending_classes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern: modes of random length
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rdy_mode_left == 0) begin
      rdy_mode      <= $urandom_range(0, 3);
      rdy_mode_left <= $urandom_range(8, 60);
    end else begin
      rdy_mode_left <= rdy_mode_left - 1;
    end
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) != 0);
      2: m_axis_tready <= (cycle_cnt % 3 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    pixel_class_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hue       = m_axis_tdata[8:0];
      got.sat       = m_axis_tdata[16:9];
      got.value     = m_axis_tdata[24:17];
      got.hue_valid = m_axis_tuser[0];
      got.skin      = m_axis_tuser[1];
      got.tint      = m_axis_tuser[2];
      if (pending_classes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported)
          $display("%0t: result with nothing pending: tdata=%h tuser=%b",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_classes.pop_front();
        if (got !== want || m_axis_tdata[31:25] !== '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReported) begin
            $write("%0t: mismatch exp hue=%0d hv=%b sat=%0d val=%0d skin=%b tint=%b",
                   $realtime, want.hue, want.hue_valid, want.sat, want.value, want.skin,
                   want.tint);
            $display(" got hue=%0d hv=%b sat=%0d val=%0d skin=%b tint=%b pad=%h",
                     got.hue, got.hue_valid, got.sat, got.value, got.skin, got.tint,
                     m_axis_tdata[31:25]);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("rgb_pixel_hue_skin_classifier_core verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SKIN_MIN_SAT;
    cfg_data_i    = '0;
    burst_left    = $urandom_range(1, 8);
    thr_skin_sat  = 32'(SKIN_MIN_SAT_RST);
    thr_skin_val  = 32'(SKIN_MIN_VAL_RST);
    thr_tint_sat  = 32'(TINT_MIN_SAT_RST);

    // r, g, b, typed, {hue, hue_valid, sat, value, skin, tint}
    dir_rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   1'b0, 8'd0,   8'd0,   1'b0, 1'b0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   1'b0, 8'd0,   8'd255, 1'b0, 1'b0}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   1'b1, 8'd255, 8'd255, 1'b0, 1'b1}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 1'b1, 8'd255, 8'd255, 1'b0, 1'b1}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 1'b1, 8'd255, 8'd255, 1'b0, 1'b1}},
      '{8'd255, 8'd255, 8'd0,   1'b0, '0},  // red and green tie
      '{8'd255, 8'd0,   8'd255, 1'b0, '0},  // red and blue tie: hue from red, no skin
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},  // green and blue tie
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // negative hue wraps
      '{8'd200, 8'd100, 8'd50,  1'b0, '0},  // green/red inside the band
      '{8'd100, 8'd37,  8'd0,   1'b0, '0},  // green/red on the low edge
      '{8'd100, 8'd80,  8'd0,   1'b0, '0},  // green/red on the high edge
      '{8'd100, 8'd81,  8'd0,   1'b0, '0},  // just above the band
      '{8'd200, 8'd10,  8'd7,   1'b0, '0},  // blue/green path
      '{8'd100, 8'd35,  8'd42,  1'b0, '0},  // blue above green, blue/red ratio on edge
      '{8'd100, 8'd20,  8'd42,  1'b0, '0},  // blue above green, green too small
      '{8'd100, 8'd0,   8'd50,  1'b0, '0},  // blue above zero green
      '{8'd53,  8'd40,  8'd40,  1'b0, '0},  // saturation at skin threshold
      '{8'd54,  8'd40,  8'd40,  1'b0, '0},  // saturation just above it
      '{8'd39,  8'd20,  8'd0,   1'b0, '0},  // value below skin threshold
      '{8'd40,  8'd20,  8'd0,   1'b0, '0},  // value at skin threshold
      '{8'd33,  8'd0,   8'd0,   1'b0, '0},  // saturation at tint threshold
      '{8'd100, 8'd120, 8'd0,   1'b0, '0}   // green on top
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows and a first random run at the reset thresholds
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].typed,
                 dir_rows[i].res);
    repeat (RandPerPhase) send_random_pixel();

    // Further phases with new thresholds, extremes first
    for (int ph = 1; ph <= 4; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      case (ph)
        1: begin
          write_threshold(REG_SKIN_MIN_SAT, 8'd0);
          write_threshold(REG_SKIN_MIN_VAL, 8'd0);
          write_threshold(REG_TINT_MIN_SAT, 8'd0);
        end
        2: begin
          write_threshold(REG_SKIN_MIN_SAT, 8'd255);
          write_threshold(REG_SKIN_MIN_VAL, 8'd255);
          write_threshold(REG_TINT_MIN_SAT, 8'd255);
        end
        3: begin
          write_threshold(REG_SKIN_MIN_SAT, ChanW'($urandom_range(0, 60)));
          write_threshold(REG_SKIN_MIN_VAL, ChanW'($urandom_range(0, 120)));
          write_threshold(REG_TINT_MIN_SAT, ChanW'($urandom));
          // unmapped index leaves every threshold alone
          write_threshold(REG_UNUSED, ChanW'($urandom));
        end
        default: begin
          write_threshold(REG_TINT_MIN_SAT, ChanW'($urandom_range(0, 80)));
          write_threshold(REG_SKIN_MIN_VAL, ChanW'($urandom));
          write_threshold(REG_SKIN_MIN_SAT, ChanW'($urandom_range(0, 30)));
        end
      endcase
      repeat (RandPerPhase) send_random_pixel();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for the pipeline depth
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_classes.size() == 0) begin
      $display("rgb_pixel_hue_skin_classifier_core verification clean");
    end else begin
      $display("rgb_pixel_hue_skin_classifier_core verification failed");
    end
    $finish;
  end

endmodule
